/* hdl/khtl_pkg.sv */
package khtl_pkg;

   // table geometry
   localparam int MAX_ENTRIES = 256;
   localparam int MAX_VALUES  = 16;

   localparam int ENTRY_W    = $clog2(MAX_ENTRIES);
   localparam int ECNT_W     = $clog2(MAX_ENTRIES + 1);
   localparam int VIDX_W     = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
   localparam int VCNT_W     = $clog2(MAX_VALUES + 1);
   localparam int VMEM_DEPTH = MAX_ENTRIES << VIDX_W;

   // word fields
   localparam int KEY_W    = 31;
   localparam int VAL_W    = 48;
   localparam int STATUS_W = 2;
   localparam int PAD_W    = 5;

   // register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] REG_PAD_COUNT = '0;

   // item modes
   localparam logic MODE_ADD    = 1'b0;
   localparam logic MODE_LOOKUP = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_FOUND     = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2,
      ST_ADDED     = 2'd3
   } khtl_status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_MISS,
      S_CNT,
      S_CALC,
      S_EMPTY,
      S_VRD,
      S_VOUT
   } khtl_state_type;

   // controller to datapath
   typedef struct packed {
      logic add;
      logic start_scan;
      logic scan_step;
      logic calc;
      logic load_miss;
      logic load_empty;
      logic emit_step;
   } khtl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
      logic scan_done;
      logic scan_miss;
      logic emit_zero;
      logic emit_last;
   } khtl_sts_type;

endpackage

/* hdl/khtl_req_if.sv */
interface khtl_req_if;
   logic                         valid;
   logic                         ready;
   logic                         mode;
   logic                         exact_match;
   logic [khtl_pkg::KEY_W-1:0]   time_key;
   logic signed [khtl_pkg::VAL_W-1:0] level_value;
   logic                         value_present;
   logic                         entry_last;

   modport source (
      output valid, mode, exact_match, time_key, level_value, value_present, entry_last,
      input  ready
   );
   modport sink (
      input  valid, mode, exact_match, time_key, level_value, value_present, entry_last,
      output ready
   );
endinterface

/* hdl/khtl_rsp_if.sv */
interface khtl_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [khtl_pkg::STATUS_W-1:0]     status;
   logic signed [khtl_pkg::VAL_W-1:0] out_value;
   logic                              out_valid;
   logic                              out_last;

   modport source (
      output valid, status, out_value, out_valid, out_last,
      input  ready
   );
   modport sink (
      input  valid, status, out_value, out_valid, out_last,
      output ready
   );
endinterface

/* hdl/keyed_history_table_lookup_top.sv */
// Keyed history table lookup.
// req_ch takes words of two kinds. An add word (mode 0) appends its value, if
// value_present, to the entry being built; the word with entry_last closes the
// entry and gives one rsp_ch word (entry added, or table full). An add word
// without entry_last gives no result.
// A lookup word (mode 1) scans the stored keys from entry 0, one key per
// cycle, then gives one or more rsp_ch words, out_last on the final one.
// The scan reads through the key memory read port, the value count is fetched
// next, then each emitted value is read through the value memory read port.
// Lookups are handled one at a time; req_ch ready is low during a lookup.
// Results leave through an output register, so a new word is taken while the
// last result still waits, as long as the receiver takes it that cycle.
// A stalled receiver holds the result and the block waits for it.
// Reset (synchronous) empties the table and clears pad_count; table contents
// are not cleared. pad_count is written over the csr_ port; the user must
// write it only while idle, as the block itself does not enforce this.
module keyed_history_table_lookup_top (
   input  logic                                clock,
   input  logic                                reset,
   khtl_req_if.sink                            req_ch,
   khtl_rsp_if.source                          rsp_ch,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [khtl_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [khtl_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [khtl_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   logic [khtl_pkg::PAD_W-1:0] pad_count_ff;
   logic                       csr_hit;
   khtl_pkg::khtl_cmd_type     cmd;
   khtl_pkg::khtl_sts_type     sts;

   // register port
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[khtl_pkg::CSR_ADDR_W-1:2] == khtl_pkg::REG_PAD_COUNT);

   always_ff @(posedge clock) begin
      if (reset) begin
         pad_count_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_hit) begin
         pad_count_ff <= csr_pwdata[khtl_pkg::PAD_W-1:0];
      end
   end

   assign csr_prdata = csr_hit ? khtl_pkg::CSR_DATA_W'(pad_count_ff) : '0;

   khtl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_mode  (req_ch.mode),
      .sts       (sts),
      .req_ready (req_ch.ready),
      .cmd       (cmd)
   );

   khtl_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .pad_count     (pad_count_ff),
      .exact_match   (req_ch.exact_match),
      .time_key      (req_ch.time_key),
      .level_value   (req_ch.level_value),
      .value_present (req_ch.value_present),
      .entry_last    (req_ch.entry_last),
      .rsp_ready     (rsp_ch.ready),
      .rsp_valid     (rsp_ch.valid),
      .rsp_status    (rsp_ch.status),
      .rsp_out_value (rsp_ch.out_value),
      .rsp_out_valid (rsp_ch.out_valid),
      .rsp_out_last  (rsp_ch.out_last)
   );

   // a word without a value always ends its item
   a_novalue_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.out_valid) |-> rsp_ch.out_last)
      else $error("result without value not marked last");

   // only a found lookup carries values
   a_value_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.out_valid) |-> (rsp_ch.status == khtl_pkg::ST_FOUND))
      else $error("value word with non-found status");

   // a lookup blocks the input the cycle after it is taken
   a_lookup_busy: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && (req_ch.mode == khtl_pkg::MODE_LOOKUP))
      |=> !req_ch.ready)
      else $error("input taken during lookup");

endmodule

/* hdl/khtl_ctrl.sv */
module khtl_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_mode,
   input  khtl_pkg::khtl_sts_type sts,
   output logic                   req_ready,
   output khtl_pkg::khtl_cmd_type cmd
);

   khtl_pkg::khtl_state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= khtl_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         khtl_pkg::S_IDLE: begin
            req_ready = sts.out_free;
            if (req_valid && sts.out_free) begin
               if (req_mode == khtl_pkg::MODE_LOOKUP) begin
                  cmd.start_scan = 1'b1;
                  state_in       = khtl_pkg::S_SCAN;
               end else begin
                  cmd.add = 1'b1;
               end
            end
         end
         khtl_pkg::S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_done) begin
               state_in = sts.scan_miss ? khtl_pkg::S_MISS : khtl_pkg::S_CNT;
            end
         end
         khtl_pkg::S_MISS: begin
            if (sts.out_free) begin
               cmd.load_miss = 1'b1;
               state_in      = khtl_pkg::S_IDLE;
            end
         end
         khtl_pkg::S_CNT: begin
            // value count read in flight
            state_in = khtl_pkg::S_CALC;
         end
         khtl_pkg::S_CALC: begin
            cmd.calc = 1'b1;
            state_in = sts.emit_zero ? khtl_pkg::S_EMPTY : khtl_pkg::S_VRD;
         end
         khtl_pkg::S_EMPTY: begin
            if (sts.out_free) begin
               cmd.load_empty = 1'b1;
               state_in       = khtl_pkg::S_IDLE;
            end
         end
         khtl_pkg::S_VRD: begin
            // value read in flight
            state_in = khtl_pkg::S_VOUT;
         end
         khtl_pkg::S_VOUT: begin
            if (sts.out_free) begin
               cmd.emit_step = 1'b1;
               state_in = sts.emit_last ? khtl_pkg::S_IDLE : khtl_pkg::S_VRD;
            end
         end
         default: begin
            state_in = khtl_pkg::S_IDLE;
         end
      endcase
   end

endmodule

/* hdl/khtl_dp.sv */
module khtl_dp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  khtl_pkg::khtl_cmd_type                 cmd,
   output khtl_pkg::khtl_sts_type                 sts,
   input  logic [khtl_pkg::PAD_W-1:0]             pad_count,
   input  logic                                   exact_match,
   input  logic [khtl_pkg::KEY_W-1:0]             time_key,
   input  logic signed [khtl_pkg::VAL_W-1:0]      level_value,
   input  logic                                   value_present,
   input  logic                                   entry_last,
   input  logic                                   rsp_ready,
   output logic                                   rsp_valid,
   output logic [khtl_pkg::STATUS_W-1:0]          rsp_status,
   output logic signed [khtl_pkg::VAL_W-1:0]      rsp_out_value,
   output logic                                   rsp_out_valid,
   output logic                                   rsp_out_last
);

   localparam int VADDR_W = khtl_pkg::ENTRY_W + khtl_pkg::VIDX_W;

   // storage
   logic [khtl_pkg::KEY_W-1:0]  key_mem [khtl_pkg::MAX_ENTRIES];
   logic [khtl_pkg::VCNT_W-1:0] cnt_mem [khtl_pkg::MAX_ENTRIES];
   logic [khtl_pkg::VAL_W-1:0]  val_mem [khtl_pkg::VMEM_DEPTH];

   logic [khtl_pkg::KEY_W-1:0]  key_rd_ff;
   logic [khtl_pkg::VCNT_W-1:0] cnt_rd_ff;
   logic [khtl_pkg::VAL_W-1:0]  val_rd_ff;

   // table state
   logic [khtl_pkg::ECNT_W-1:0] entry_count_ff, entry_count_in;
   logic [khtl_pkg::VCNT_W-1:0] build_index_ff, build_index_in;

   // lookup state
   logic [khtl_pkg::KEY_W-1:0]   target_ff;
   logic                         exact_ff;
   logic [khtl_pkg::ECNT_W-1:0]  idx_ff;
   logic                         pend_ff;
   logic [khtl_pkg::ENTRY_W-1:0] pend_idx_ff;
   logic [khtl_pkg::ENTRY_W-1:0] sel_ff, sel_in;
   logic                         have_ff, have_in;
   logic [khtl_pkg::VCNT_W-1:0]  stored_ff, stored_c;
   logic [khtl_pkg::VCNT_W-1:0]  emit_ff, emit_c;
   logic [khtl_pkg::VCNT_W-1:0]  vi_ff;

   // result register
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [khtl_pkg::STATUS_W-1:0]        rsp_status_ff;
   logic signed [khtl_pkg::VAL_W-1:0]    rsp_value_ff;
   logic                                 rsp_out_valid_ff;
   logic                                 rsp_out_last_ff;

   logic                         out_free;
   logic                         table_full;
   logic                         val_take;
   logic                         key_we;
   logic                         val_we;
   logic                         issue;
   logic                         key_hit;
   logic                         hit;
   logic                         scan_end;
   logic                         scan_done;
   logic [khtl_pkg::ECNT_W-1:0]  last_entry;
   logic [VADDR_W-1:0]           val_wr_addr;
   logic [VADDR_W-1:0]           val_rd_addr;
   logic [khtl_pkg::VCNT_W-1:0]  cnt_clamp;
   logic                         emit_last;

   // add path
   assign table_full  = (entry_count_ff == khtl_pkg::ECNT_W'(khtl_pkg::MAX_ENTRIES));
   assign val_take    = value_present &&
                        (build_index_ff < khtl_pkg::VCNT_W'(khtl_pkg::MAX_VALUES));
   assign val_we      = cmd.add && val_take && !table_full;
   assign key_we      = cmd.add && entry_last && !table_full;
   assign val_wr_addr = {entry_count_ff[khtl_pkg::ENTRY_W-1:0],
                         build_index_ff[khtl_pkg::VIDX_W-1:0]};
   assign val_rd_addr = {sel_ff, vi_ff[khtl_pkg::VIDX_W-1:0]};

   always_comb begin
      entry_count_in = entry_count_ff;
      build_index_in = build_index_ff;
      if (cmd.add) begin
         if (entry_last) begin
            build_index_in = '0;
            if (!table_full) begin
               entry_count_in = entry_count_ff + khtl_pkg::ECNT_W'(1);
            end
         end else begin
            build_index_in = build_index_ff + khtl_pkg::VCNT_W'(val_take);
         end
      end
   end

   // memories, registered reads
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[entry_count_ff[khtl_pkg::ENTRY_W-1:0]] <= time_key;
      end
      key_rd_ff <= key_mem[idx_ff[khtl_pkg::ENTRY_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         cnt_mem[entry_count_ff[khtl_pkg::ENTRY_W-1:0]] <=
            build_index_ff + khtl_pkg::VCNT_W'(val_take);
      end
      cnt_rd_ff <= cnt_mem[sel_ff];
   end

   always_ff @(posedge clock) begin
      if (val_we) begin
         val_mem[val_wr_addr] <= level_value;
      end
      val_rd_ff <= val_mem[val_rd_addr];
   end

   // scan: one key issued per cycle, compared in the cycle after
   assign issue      = (idx_ff < entry_count_ff);
   assign key_hit    = exact_ff ? (key_rd_ff == target_ff) : (key_rd_ff > target_ff);
   assign hit        = pend_ff && key_hit;
   assign scan_end   = !pend_ff && !issue;
   assign scan_done  = hit || scan_end;
   assign last_entry = entry_count_ff - khtl_pkg::ECNT_W'(1);

   always_comb begin
      sel_in  = sel_ff;
      have_in = have_ff;
      if (hit) begin
         have_in = 1'b1;
         if (exact_ff || (pend_idx_ff == '0)) begin
            sel_in = pend_idx_ff;
         end else begin
            sel_in = pend_idx_ff - khtl_pkg::ENTRY_W'(1);
         end
      end else if (exact_ff) begin
         have_in = 1'b0;
      end else begin
         have_in = (entry_count_ff != '0);
         sel_in  = (entry_count_ff == '0) ? '0 : last_entry[khtl_pkg::ENTRY_W-1:0];
      end
   end

   // emit count
   always_comb begin
      cnt_clamp = (cnt_rd_ff > khtl_pkg::VCNT_W'(khtl_pkg::MAX_VALUES)) ?
                  khtl_pkg::VCNT_W'(khtl_pkg::MAX_VALUES) : cnt_rd_ff;
      stored_c  = have_ff ? cnt_clamp : '0;
      if (pad_count == '0) begin
         emit_c = stored_c;
      end else if (32'(pad_count) > 32'(khtl_pkg::MAX_VALUES)) begin
         emit_c = khtl_pkg::VCNT_W'(khtl_pkg::MAX_VALUES);
      end else begin
         emit_c = khtl_pkg::VCNT_W'(pad_count);
      end
   end

   assign emit_last = ((vi_ff + khtl_pkg::VCNT_W'(1)) == emit_ff);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
         build_index_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         entry_count_ff <= entry_count_in;
         build_index_ff <= build_index_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // lookup registers
   always_ff @(posedge clock) begin
      if (cmd.start_scan) begin
         target_ff <= time_key;
         exact_ff  <= exact_match;
         idx_ff    <= '0;
         pend_ff   <= 1'b0;
      end else if (cmd.scan_step) begin
         pend_ff     <= issue;
         pend_idx_ff <= idx_ff[khtl_pkg::ENTRY_W-1:0];
         if (issue) begin
            idx_ff <= idx_ff + khtl_pkg::ECNT_W'(1);
         end
         if (scan_done) begin
            sel_ff  <= sel_in;
            have_ff <= have_in;
         end
      end
      if (cmd.calc) begin
         stored_ff <= stored_c;
         emit_ff   <= emit_c;
         vi_ff     <= '0;
      end else if (cmd.emit_step) begin
         vi_ff <= vi_ff + khtl_pkg::VCNT_W'(1);
      end
   end

   // result register load
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if ((cmd.add && entry_last) || cmd.load_miss || cmd.load_empty || cmd.emit_step) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      priority if (cmd.add && entry_last) begin
         rsp_status_ff    <= table_full ? khtl_pkg::ST_FULL : khtl_pkg::ST_ADDED;
         rsp_value_ff     <= '0;
         rsp_out_valid_ff <= 1'b0;
         rsp_out_last_ff  <= 1'b1;
      end else if (cmd.load_miss) begin
         rsp_status_ff    <= khtl_pkg::ST_NOT_FOUND;
         rsp_value_ff     <= '0;
         rsp_out_valid_ff <= 1'b0;
         rsp_out_last_ff  <= 1'b1;
      end else if (cmd.load_empty) begin
         rsp_status_ff    <= khtl_pkg::ST_FOUND;
         rsp_value_ff     <= '0;
         rsp_out_valid_ff <= 1'b0;
         rsp_out_last_ff  <= 1'b1;
      end else if (cmd.emit_step) begin
         // past the stored values the word is zero padding
         rsp_status_ff    <= khtl_pkg::ST_FOUND;
         rsp_value_ff     <= (vi_ff < stored_ff) ? val_rd_ff : '0;
         rsp_out_valid_ff <= 1'b1;
         rsp_out_last_ff  <= emit_last;
      end else begin
         rsp_status_ff    <= rsp_status_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_out_valid = rsp_out_valid_ff;
   assign rsp_out_last  = rsp_out_last_ff;

   // status to controller
   assign sts.out_free  = out_free;
   assign sts.scan_done = scan_done;
   assign sts.scan_miss = exact_ff && !hit;
   assign sts.emit_zero = (emit_c == '0);
   assign sts.emit_last = emit_last;

endmodule

/* tb/khtl_reply_check.sv */
`timescale 1ns / 100ps

// Watches both channels and the register port, keeps its own copy of the
// history table and checks every reply word against the oldest one due.
module khtl_reply_check
   import khtl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   khtl_req_if                   req_ch,
   khtl_rsp_if                   rsp_ch,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic                  csr_pready,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output int                    errors,
   output int                    pending
);

   typedef struct {
      khtl_status_type         status;
      logic signed [VAL_W-1:0] value;
      logic                    carries;
      logic                    closing;
   } reply_word_type;

   // table copy
   logic [KEY_W-1:0]        key_tbl [MAX_ENTRIES];
   logic signed [VAL_W-1:0] level_tbl [MAX_ENTRIES][MAX_VALUES];
   int unsigned             count_tbl [MAX_ENTRIES];
   int unsigned             n_entries;
   int unsigned             n_building;
   int unsigned             pad_setting;
   int                      fail_total = 0;

   reply_word_type replies_due[$];

   function automatic void queue_reply(khtl_status_type st, logic signed [VAL_W-1:0] v,
                                       logic carries, logic closing);
      reply_word_type w;
      w.status  = st;
      w.value   = v;
      w.carries = carries;
      w.closing = closing;
      replies_due.push_back(w);
   endfunction

   // work out the replies one request word causes, and update the table copy
   function automatic void table_replies(logic md, logic ex, logic [KEY_W-1:0] key,
                                         logic signed [VAL_W-1:0] lvl, logic pres,
                                         logic lst);
      int unsigned hit;
      int unsigned i;
      int unsigned stored;
      int unsigned emit;
      bit          found;
      if (md == MODE_ADD) begin
         // values past the entry's capacity are dropped
         if (pres && n_building < MAX_VALUES) begin
            if (n_entries < MAX_ENTRIES) level_tbl[n_entries][n_building] = lvl;
            n_building++;
         end
         if (lst) begin
            if (n_entries >= MAX_ENTRIES) begin
               queue_reply(ST_FULL, '0, 1'b0, 1'b1);
            end else begin
               key_tbl[n_entries]   = key;
               count_tbl[n_entries] = n_building;
               n_entries++;
               queue_reply(ST_ADDED, '0, 1'b0, 1'b1);
            end
            n_building = 0;
         end
      end else begin
         hit   = 0;
         found = 1'b0;
         if (ex) begin
            for (i = 0; i < n_entries && !found; i++) begin
               if (key_tbl[i] == key) begin
                  hit   = i;
                  found = 1'b1;
               end
            end
         end else begin
            // entry before the first key above the target, else entry 0
            i = 0;
            while (i < n_entries && key_tbl[i] <= key) i++;
            hit   = (i > 0) ? i - 1 : 0;
            found = (n_entries > 0);
         end
         if (ex && !found) begin
            queue_reply(ST_NOT_FOUND, '0, 1'b0, 1'b1);
         end else begin
            stored = found ? count_tbl[hit] : 0;
            if (pad_setting != 0) emit = (pad_setting > MAX_VALUES) ? MAX_VALUES : pad_setting;
            else emit = stored;
            if (emit == 0) begin
               queue_reply(ST_FOUND, '0, 1'b0, 1'b1);
            end else begin
               for (i = 0; i < emit; i++)
                  queue_reply(ST_FOUND, (i < stored) ? level_tbl[hit][i] : '0, 1'b1,
                              i + 1 == emit);
            end
         end
      end
   endfunction

   always @(posedge clock) begin
      reply_word_type want;
      if (reset) begin
         n_entries   = 0;
         n_building  = 0;
         pad_setting = 0;
         replies_due.delete();
      end else begin
         // register writes
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[CSR_ADDR_W-1:2] == REG_PAD_COUNT)
            pad_setting = 32'(csr_pwdata[PAD_W-1:0]);

         if (req_ch.valid && req_ch.ready)
            table_replies(req_ch.mode, req_ch.exact_match, req_ch.time_key,
                          req_ch.level_value, req_ch.value_present, req_ch.entry_last);

         // reply words, in order
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (replies_due.size() == 0) begin
               $display("%0t: unexpected reply word: status %0d value %0d valid %0d last %0d",
                        $time, rsp_ch.status, rsp_ch.out_value, rsp_ch.out_valid,
                        rsp_ch.out_last);
               fail_total++;
            end else begin
               want = replies_due.pop_front();
               if (rsp_ch.status !== want.status || rsp_ch.out_value !== want.value ||
                   rsp_ch.out_valid !== want.carries || rsp_ch.out_last !== want.closing) begin
                  $display("%0t: reply mismatch: expected status %0d value %0d valid %0d last %0d",
                           $time, want.status, want.value, want.carries, want.closing);
                  $display("%0t:                  got status %0d value %0d valid %0d last %0d",
                           $time, rsp_ch.status, rsp_ch.out_value, rsp_ch.out_valid,
                           rsp_ch.out_last);
                  fail_total++;
               end
            end
         end
      end
      errors  <= fail_total;
      pending <= replies_due.size();
   end

endmodule

/* tb/keyed_history_table_lookup_top_test.sv */
`timescale 1ns / 100ps

module keyed_history_table_lookup_top_test;
   import khtl_pkg::*;

   localparam int QUIET_LIMIT = 4000;
   localparam logic [KEY_W-1:0]        KEY_MAX = '1;
   localparam logic signed [VAL_W-1:0] LVL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
   localparam logic signed [VAL_W-1:0] LVL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   int                    errors;
   int                    pending;

   khtl_req_if req_ch ();
   khtl_rsp_if rsp_ch ();

   keyed_history_table_lookup_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   khtl_reply_check reply_check (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_pready  (csr_pready),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .errors      (errors),
      .pending     (pending)
   );

   always #6 clock = ~clock;

   // idling and stalling, in percent of cycles
   int send_idle_pct = 0;
   int stall_pct     = 0;

   // stimulus bookkeeping
   int               words_sent   = 0;
   int               entries_made = 0;
   logic [KEY_W-1:0] history_key;
   logic [KEY_W-1:0] key_log[$];

   // receiver stalls
   always @(negedge clock) begin
      rsp_ch.ready = ($urandom_range(0, 99) >= stall_pct);
   end

   // watchdog: too long without any word moving on either channel
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // one request word; starts and ends at a falling edge
   task automatic push_word(logic md, logic ex, logic [KEY_W-1:0] key,
                            logic signed [VAL_W-1:0] lvl, logic pres, logic lst);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.mode          = md;
      req_ch.exact_match   = ex;
      req_ch.time_key      = key;
      req_ch.level_value   = lvl;
      req_ch.value_present = pres;
      req_ch.entry_last    = lst;
      req_ch.valid         = 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      words_sent++;
      if (md == MODE_ADD && lst && entries_made < MAX_ENTRIES) begin
         entries_made++;
         key_log.push_back(key);
      end
      @(negedge clock);
   endtask

   // write pad_count once nothing is in flight
   task automatic write_pad(int unsigned v);
      req_ch.valid = 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      // an add word without entry_last may still be in the block
      repeat (8) @(posedge clock);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_pwrite  = 1'b1;
      csr_penable = 1'b0;
      csr_paddr   = {REG_PAD_COUNT, 2'b00};
      csr_pwdata  = v;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   function automatic logic signed [VAL_W-1:0] pick_level();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0: return LVL_MIN;
         1: return LVL_MAX;
         2: return '1;
         3: return '0;
         default: return raw[VAL_W-1:0];
      endcase
   endfunction

   // keys mostly climb like time stamps, with repeats and outliers
   function automatic logic [KEY_W-1:0] next_add_key();
      logic [31:0] raw;
      raw = $urandom;
      case ($urandom_range(0, 19))
         0: return raw[KEY_W-1:0];
         1: return history_key;
         default: begin
            history_key = history_key + KEY_W'($urandom_range(1, 40));
            return history_key;
         end
      endcase
   endfunction

   function automatic logic [KEY_W-1:0] pick_lookup_key(logic ex);
      logic [KEY_W-1:0] k;
      logic [31:0]      raw;
      raw = $urandom;
      if (key_log.size() != 0 && $urandom_range(0, 9) < 6) begin
         k = key_log[$urandom_range(0, key_log.size() - 1)];
         if (!ex && $urandom_range(0, 1))
            k = k + KEY_W'($urandom_range(0, 30)) - KEY_W'(15);
      end else begin
         case ($urandom_range(0, 4))
            0: k = '0;
            1: k = KEY_MAX;
            2: k = history_key - KEY_W'($urandom_range(0, 300));
            default: k = raw[KEY_W-1:0];
         endcase
      end
      return k;
   endfunction

   // one entry of nvals values, with the odd empty word mixed in
   task automatic add_entry(logic [KEY_W-1:0] key, int nvals);
      int          i;
      logic        blank_close;
      logic [31:0] raw;
      blank_close = (nvals == 0) || ($urandom_range(0, 9) == 0);
      for (i = 0; i < nvals; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            raw = $urandom;
            push_word(MODE_ADD, 1'($urandom_range(0, 1)), raw[KEY_W-1:0], pick_level(),
                      1'b0, 1'b0);
         end
         raw = $urandom;
         push_word(MODE_ADD, 1'($urandom_range(0, 1)),
                   (i == nvals - 1 && !blank_close) ? key : raw[KEY_W-1:0],
                   pick_level(), 1'b1, (i == nvals - 1) && !blank_close);
      end
      if (blank_close)
         push_word(MODE_ADD, 1'($urandom_range(0, 1)), key, pick_level(), 1'b0, 1'b1);
   endtask

   // lookup word; value fields carry noise
   task automatic lookup(logic ex, logic [KEY_W-1:0] key);
      push_word(MODE_LOOKUP, ex, key, pick_level(), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
   endtask

   task automatic random_op();
      int   nvals;
      logic ex;
      if ($urandom_range(0, 99) < 55) begin
         nvals = ($urandom_range(0, 9) == 0) ? $urandom_range(5, MAX_VALUES + 2)
                                              : $urandom_range(0, 4);
         add_entry(next_add_key(), nvals);
      end else begin
         ex = 1'($urandom_range(0, 1));
         lookup(ex, pick_lookup_key(ex));
      end
   endtask

   int unsigned pad_plan [8] = '{0, 16, 1, 0, 31, 5, 16, 0};
   int          idle_plan[4] = '{0, 64, 0, 7};
   int          stall_plan[4] = '{0, 0, 64, 7};

   initial begin
      int i;
      int p;
      req_ch.valid         = 1'b0;
      req_ch.mode          = MODE_ADD;
      req_ch.exact_match   = 1'b0;
      req_ch.time_key      = '0;
      req_ch.level_value   = '0;
      req_ch.value_present = 1'b0;
      req_ch.entry_last    = 1'b0;
      rsp_ch.ready         = 1'b0;
      csr_psel             = 1'b0;
      csr_penable          = 1'b0;
      csr_pwrite           = 1'b0;
      csr_paddr            = '0;
      csr_pwdata           = '0;
      history_key          = KEY_W'($urandom_range(1000, 5000));

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty table: round down gives an empty reply or padding, exact misses
      lookup(1'b0, 31'd5);
      lookup(1'b1, 31'd0);
      write_pad(3);
      lookup(1'b0, KEY_MAX);
      write_pad(0);

      // entry with extreme values, an entry with none, an overfull entry
      push_word(MODE_ADD, 1'b0, 31'd1, LVL_MIN, 1'b1, 1'b0);
      push_word(MODE_ADD, 1'b1, 31'd1, LVL_MAX, 1'b1, 1'b1);
      push_word(MODE_ADD, 1'b0, 31'd100, '0, 1'b0, 1'b1);
      for (i = 0; i <= MAX_VALUES; i++)
         push_word(MODE_ADD, 1'b0, KEY_MAX, (i == 0) ? '1 : (i == 1) ? '0 : pick_level(),
                   1'b1, i == MAX_VALUES);

      // hits, a miss, round down below the first key, within and past the end
      lookup(1'b1, 31'd100);
      lookup(1'b1, 31'd1);
      lookup(1'b1, 31'd55);
      lookup(1'b0, 31'd0);
      lookup(1'b0, 31'd50);
      lookup(1'b0, KEY_MAX);

      // duplicate key: the first entry with it wins
      push_word(MODE_ADD, 1'b0, 31'd100, pick_level(), 1'b1, 1'b1);
      lookup(1'b1, 31'd100);

      // random phases over pad settings and idling patterns
      for (p = 0; p < 8; p++) begin
         write_pad(pad_plan[p]);
         send_idle_pct = idle_plan[p % 4];
         stall_pct     = stall_plan[p % 4];
         while (words_sent < 30 + (p + 1) * 30) random_op();
      end

      // fill the table, then add past its end
      write_pad(0);
      send_idle_pct = 7;
      stall_pct     = 7;
      while (entries_made < MAX_ENTRIES)
         add_entry(next_add_key(), ($urandom_range(0, 9) == 0) ? 1 : 0);
      add_entry(next_add_key(), 0);
      add_entry(next_add_key(), 3);
      for (i = 0; i < 6; i++) random_op();
      write_pad(16);
      for (i = 0; i < 4; i++) lookup(1'($urandom_range(0, 1)), pick_lookup_key(1'b0));

      // drain
      req_ch.valid = 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
